// ===== rtl/core/bitmap_grid_rect_fill_query_defines.svh =====
// Assertion helpers for the bitmap grid block.
// Each macro expects clk_i and rst_ni in scope.
`ifndef BITMAP_GRID_RECT_FILL_QUERY_DEFINES_SVH
`define BITMAP_GRID_RECT_FILL_QUERY_DEFINES_SVH

// Same-cycle implication, checked only outside reset.
`define BGRF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked only outside reset.
`define BGRF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/bgrf_pkg.sv =====
`default_nettype none
package bgrf_pkg;

  // Request codes.
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_FILL  = 2'd2;
  localparam logic [1:0] FUNC_TEST  = 2'd3;

  // Coordinate widths follow the request fields; offsets cover words up to 64 bits.
  localparam int X_W       = 9;
  localparam int Y_W       = 9;
  localparam int OFS_MAX_W = 6;

  // One rectangle walk, already checked and reduced to columns and words.
  typedef struct packed {
    logic [X_W-1:0]       x_lo;
    logic [X_W-1:0]       x_hi;
    logic [Y_W-1:0]       w_lo;
    logic [Y_W-1:0]       w_hi;
    logic [OFS_MAX_W-1:0] ofs_lo;
    logic [OFS_MAX_W-1:0] ofs_hi;
    logic                 fill;
    logic                 val;
  } bgrf_job_t;

  // Result of a finished walk.
  typedef struct packed {
    logic done;
    logic hit;
  } bgrf_res_t;

endpackage
`default_nettype wire

// ===== rtl/core/bgrf_mem.sv =====
`default_nettype none
module bgrf_mem #(
  parameter int DATA_W = 32,
  parameter int DEPTH  = 2048,
  parameter int ADDR_W = 11
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Single write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/bgrf_seq.sv =====
`default_nettype none
module bgrf_seq #(
  parameter int BITS_PER_WORD    = 32,
  parameter int WORDS_PER_COLUMN = 8,
  parameter int DEPTH            = 2048,
  parameter int ADDR_W           = 11
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     go_i,
  input  wire bgrf_pkg::bgrf_job_t      job_i,
  output logic                          busy_o,
  output bgrf_pkg::bgrf_res_t           res_o,
  output logic                          we_o,
  output logic [ADDR_W-1:0]             waddr_o,
  output logic [BITS_PER_WORD-1:0]      wdata_o,
  output logic [ADDR_W-1:0]             raddr_o,
  input  wire logic [BITS_PER_WORD-1:0] rdata_i
);
  import bgrf_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CLEAR = 2'd1;
  localparam logic [1:0] ST_WALK  = 2'd2;
  localparam logic [1:0] ST_DRAIN = 2'd3;

  logic [1:0]               state_q, state_d;
  logic [ADDR_W-1:0]        clr_q, clr_d;
  logic                     hit_q, hit_d;
  logic                     b_valid_q, b_valid_d;
  bgrf_res_t                res_q, res_d;
  bgrf_job_t                job_q, job_d;
  logic [X_W-1:0]           x_q, x_d;
  logic [Y_W-1:0]           w_q, w_d;
  logic [ADDR_W-1:0]        col_base_q, col_base_d;
  logic [ADDR_W-1:0]        b_addr_q;
  logic [BITS_PER_WORD-1:0] b_mask_q, mask;
  logic [ADDR_W-1:0]        rd_addr;
  logic [OFS_MAX_W-1:0]     lo, hi;
  logic                     b_hit;
  logic [X_W-1:0]           x_next;

  // Edge masks for the word being issued: partial only on the first and last word row.
  always_comb begin
    lo = (w_q == job_q.w_lo) ? job_q.ofs_lo : '0;
    hi = (w_q == job_q.w_hi) ? job_q.ofs_hi : OFS_MAX_W'(BITS_PER_WORD - 1);
    for (int i = 0; i < BITS_PER_WORD; i++) begin
      mask[i] = (OFS_MAX_W'(i) >= lo) && (OFS_MAX_W'(i) <= hi);
    end
  end

  assign rd_addr = col_base_q + ADDR_W'(w_q);
  assign x_next  = x_q + X_W'(1);

  // The second stage sees the word read in the previous cycle.
  assign b_hit = b_valid_q && !job_q.fill &&
                 (job_q.val ? |(rdata_i & b_mask_q) : |(~rdata_i & b_mask_q));

  // Sequencer: clearing pass after reset, then rectangle walks.
  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    hit_d      = hit_q;
    job_d      = job_q;
    x_d        = x_q;
    w_d        = w_q;
    col_base_d = col_base_q;
    b_valid_d  = 1'b0;
    res_d      = '0;
    if (b_hit) begin
      hit_d = 1'b1;
    end
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + ADDR_W'(1);
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (go_i) begin
          job_d      = job_i;
          x_d        = job_i.x_lo;
          w_d        = job_i.w_lo;
          col_base_d = ADDR_W'(32'(job_i.x_lo) * WORDS_PER_COLUMN);
          hit_d      = 1'b0;
          state_d    = ST_WALK;
        end
      end
      ST_WALK: begin
        b_valid_d = 1'b1;
        if (w_q == job_q.w_hi) begin
          w_d        = job_q.w_lo;
          x_d        = x_next;
          col_base_d = col_base_q + ADDR_W'(WORDS_PER_COLUMN);
          if (x_next == job_q.x_hi) begin
            state_d = ST_DRAIN;
          end
        end else begin
          w_d = w_q + Y_W'(1);
        end
      end
      ST_DRAIN: begin
        res_d.done = 1'b1;
        res_d.hit  = hit_q | b_hit;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      b_valid_q <= 1'b0;
      res_q     <= '0;
      hit_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      b_valid_q <= b_valid_d;
      res_q     <= res_d;
      hit_q     <= hit_d;
    end
  end

  // Walk payload registers.
  always_ff @(posedge clk_i) begin
    job_q      <= job_d;
    x_q        <= x_d;
    w_q        <= w_d;
    col_base_q <= col_base_d;
    b_addr_q   <= rd_addr;
    b_mask_q   <= mask;
  end

  // Memory port: clearing writes zero, fills write back the modified word.
  always_comb begin
    if (state_q == ST_CLEAR) begin
      we_o    = 1'b1;
      waddr_o = clr_q;
      wdata_o = '0;
    end else begin
      we_o    = b_valid_q && job_q.fill;
      waddr_o = b_addr_q;
      wdata_o = job_q.val ? (rdata_i | b_mask_q) : (rdata_i & ~b_mask_q);
    end
  end

  assign raddr_o = rd_addr;
  assign busy_o  = (state_q != ST_IDLE);
  assign res_o   = res_q;

endmodule
`default_nettype wire

// ===== rtl/core/bitmap_grid_rect_fill_query.sv =====
// Rejected and empty requests answer in the cycle after they are taken.
// Other requests walk the bitmap memory one word per cycle through a read-modify-write
// pipeline, over every word that the rectangle touches in each column of its x span (one for a cell).
// Busy stays high until the result strobe; one request is in flight at a time.
// After reset the memory is cleared, one word per cycle, over all GRID_WIDTH * words per column
// words (2048 by default) with busy high. The receiver cannot stall.
`default_nettype none
`include "bitmap_grid_rect_fill_query_defines.svh"
module bitmap_grid_rect_fill_query #(
  parameter int GRID_WIDTH    = 256,
  parameter int GRID_HEIGHT   = 256,
  parameter int BITS_PER_WORD = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] func_i,
  input  wire logic [7:0] x_min_i,
  input  wire logic [7:0] y_min_i,
  input  wire logic [8:0] x_max_i,
  input  wire logic [8:0] y_max_i,
  input  wire logic       value_i,
  output logic            done_o,
  output logic            answer_o,
  output logic            error_o
);
  import bgrf_pkg::*;

  // BITS_PER_WORD must be a power of two.
  localparam int WORDS_PER_COLUMN = (GRID_HEIGHT + BITS_PER_WORD - 1) / BITS_PER_WORD;
  localparam int DEPTH            = GRID_WIDTH * WORDS_PER_COLUMN;
  localparam int ADDR_W           = $clog2(DEPTH);
  localparam int OFS_W            = $clog2(BITS_PER_WORD);

  logic                     accept;
  logic                     is_cell, cell_bad, rect_bad, bad, empty;
  logic [X_W-1:0]           x0, x1;
  logic [Y_W-1:0]           y0, y_last;
  bgrf_job_t                job;
  logic                     go;
  logic                     seq_busy;
  bgrf_res_t                seq_res;
  logic                     imm_q, imm_err_q;
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr, mem_raddr;
  logic [BITS_PER_WORD-1:0] mem_wdata, mem_rdata;

  assign accept = start && !busy;

  // Check the request and reduce it to a rectangle of columns and word rows.
  always_comb begin
    is_cell  = (func_i == FUNC_READ) || (func_i == FUNC_WRITE);
    x0       = {1'b0, x_min_i};
    y0       = {1'b0, y_min_i};
    cell_bad = (32'(x0) >= 32'(GRID_WIDTH)) || (32'(y0) >= 32'(GRID_HEIGHT));
    rect_bad = cell_bad || (32'(x_max_i) > 32'(GRID_WIDTH)) ||
               (32'(y_max_i) > 32'(GRID_HEIGHT)) || (x0 > x_max_i) || (y0 > y_max_i);
    bad      = is_cell ? cell_bad : rect_bad;
    empty    = !is_cell && ((x0 == x_max_i) || (y0 == y_max_i));
    x1       = is_cell ? (x0 + X_W'(1)) : x_max_i;
    y_last   = is_cell ? y0 : (y_max_i - Y_W'(1));

    job.x_lo   = x0;
    job.x_hi   = x1;
    job.w_lo   = y0 >> OFS_W;
    job.w_hi   = y_last >> OFS_W;
    job.ofs_lo = OFS_MAX_W'(y0 & Y_W'(BITS_PER_WORD - 1));
    job.ofs_hi = OFS_MAX_W'(y_last & Y_W'(BITS_PER_WORD - 1));
    job.fill   = (func_i == FUNC_WRITE) || (func_i == FUNC_FILL);
    // A cell read is a test for a set bit over one cell.
    job.val    = (func_i == FUNC_READ) ? 1'b1 : value_i;

    go = accept && !bad && !empty;
  end

  // Rejected and empty requests answer on their own, in the cycle after they are taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imm_q     <= 1'b0;
      imm_err_q <= 1'b0;
    end else begin
      imm_q     <= accept && (bad || empty);
      imm_err_q <= bad;
    end
  end

  bgrf_seq #(
    .BITS_PER_WORD   (BITS_PER_WORD),
    .WORDS_PER_COLUMN(WORDS_PER_COLUMN),
    .DEPTH           (DEPTH),
    .ADDR_W          (ADDR_W)
  ) u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (go),
    .job_i  (job),
    .busy_o (seq_busy),
    .res_o  (seq_res),
    .we_o   (mem_we),
    .waddr_o(mem_waddr),
    .wdata_o(mem_wdata),
    .raddr_o(mem_raddr),
    .rdata_i(mem_rdata)
  );

  bgrf_mem #(
    .DATA_W(BITS_PER_WORD),
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Result beat.
  assign busy     = seq_busy;
  assign done_o   = seq_res.done || imm_q;
  assign answer_o = seq_res.done && seq_res.hit;
  assign error_o  = imm_q && imm_err_q;

  // Every taken request is either in progress or answered in the next cycle.
  `BGRF_ASSERT_NXT(a_accept_resp, start && !busy, busy || done_o, "request lost after accept")
  // A result beat has a cause in the cycle before.
  `BGRF_ASSERT_IMP(a_done_cause, done_o, $past(busy) || $past(start), "result without request")
  // The walk and the short path never answer in the same cycle.
  `BGRF_ASSERT_IMP(a_one_source, seq_res.done, !imm_q, "two results in one cycle")
  // Memory writes happen only while the block is busy.
  `BGRF_ASSERT_IMP(a_we_busy, mem_we, busy, "memory write while idle")

endmodule
`default_nettype wire
